// ----- rtl/fas_pkg.sv -----
// ---------------------------------------------------------------------------
// fas_pkg: shared types and constants for the flight arming supervisor
// Word layouts, error and gesture codes, register indexes and switch levels.
// ---------------------------------------------------------------------------
package fas_pkg;

   // function select of a request word
   localparam logic FUNC_ARM_CHECK = 1'b0;
   localparam logic FUNC_STOP_CHECK = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THROTTLE_TH = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PITCH_TH = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROLL_TH = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_YAW_TH = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TICKS = 3'd4;

   // register reset values
   localparam logic [8:0] TH_RESET = 9'd400;
   localparam logic [15:0] HOLD_RESET = 16'd1000;

   // stop switch bands and power limit
   localparam logic signed [10:0] STOP_LOW_LEVEL = -11'sd100;
   localparam logic signed [10:0] STOP_HIGH_LEVEL = 11'sd300;
   localparam logic [2:0] POWER_MAX_OK = 3'd2;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0,
      ERR_IMU = 3'd1,
      ERR_BARO = 3'd2,
      ERR_INERTIAL = 3'd3,
      ERR_POWER = 3'd4,
      ERR_FLASH = 3'd5
   } arm_err_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_TIMING = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   // request word without the tick count
   typedef struct packed {
      logic func;
      logic [9:0] throttle;
      logic [9:0] roll;
      logic [9:0] pitch;
      logic [9:0] yaw;
      logic [9:0] aux_stop;
      logic [3:0] sensor_ok_bits;
      logic [2:0] power_level;
      logic flash_busy;
   } req_type;

   typedef struct packed {
      logic [8:0] throttle_th;
      logic [8:0] pitch_th;
      logic [8:0] roll_th;
      logic [8:0] yaw_th;
      logic [15:0] hold_ticks;
   } cfg_type;

   // supervisor control state
   typedef struct packed {
      logic armed;
      logic arm_cmd;
      phase_type phase;
      logic stop_latched;
      logic baro_led;
      logic inertial_led;
   } ctl_type;

   typedef struct packed {
      logic armed;
      logic arm_request;
      arm_err_type arm_error;
      logic throttle_low;
      logic baro_fault_seen;
      logic inertial_fault_seen;
      logic stop_fired;
   } rsp_type;

endpackage

// ----- rtl/fas_eval.sv -----
// ---------------------------------------------------------------------------
// fas_eval: single-pass evaluation of one supervisor word
// Computes the error code, throttle flag, gesture timing, arm command and
// emergency stop handling, giving next control state and the response word.
// ---------------------------------------------------------------------------
module fas_eval #(
   parameter int unsigned TICK_WIDTH = 32
) (
   input fas_pkg::req_type item,
   input logic [TICK_WIDTH-1:0] tick,
   input fas_pkg::cfg_type cfg,
   input fas_pkg::ctl_type ctl,
   input logic [TICK_WIDTH-1:0] start,
   output fas_pkg::ctl_type ctl_next,
   output logic [TICK_WIDTH-1:0] start_next,
   output fas_pkg::rsp_type rsp
);
   import fas_pkg::*;

   logic signed [10:0] thr_x, rol_x, pit_x, yaw_x, aux_x;
   logic signed [10:0] thr_lim, pit_lim, rol_lim, yaw_lim;
   arm_err_type err;
   logic gesture_held;
   logic [TICK_WIDTH-1:0] start_eff;
   logic [TICK_WIDTH-1:0] elapsed;
   logic timing_eff;
   logic fired;

   // sign-extended stick values and threshold limits
   assign thr_x = $signed({item.throttle[9], item.throttle});
   assign rol_x = $signed({item.roll[9], item.roll});
   assign pit_x = $signed({item.pitch[9], item.pitch});
   assign yaw_x = $signed({item.yaw[9], item.yaw});
   assign aux_x = $signed({item.aux_stop[9], item.aux_stop});
   assign thr_lim = 11'sd0 - $signed({2'b00, cfg.throttle_th});
   assign pit_lim = 11'sd0 - $signed({2'b00, cfg.pitch_th});
   assign rol_lim = 11'sd0 - $signed({2'b00, cfg.roll_th});
   assign yaw_lim = $signed({2'b00, cfg.yaw_th});

   // prioritized error code, flash first
   always_comb begin
      priority if (item.flash_busy) begin
         err = ERR_FLASH;
      end else if (item.power_level > POWER_MAX_OK) begin
         err = ERR_POWER;
      end else if (!item.sensor_ok_bits[2] && !item.sensor_ok_bits[3]) begin
         err = ERR_INERTIAL;
      end else if (!item.sensor_ok_bits[1]) begin
         err = ERR_BARO;
      end else if (!item.sensor_ok_bits[0]) begin
         err = ERR_IMU;
      end else begin
         err = ERR_NONE;
      end
   end

   // inner-eight gesture and its hold time
   assign gesture_held = (thr_x < thr_lim) && (pit_x < pit_lim) &&
                         (rol_x < rol_lim) && (yaw_x > yaw_lim);
   assign start_eff = (ctl.phase == PH_IDLE) ? tick : start;
   assign timing_eff = (ctl.phase == PH_IDLE) || (ctl.phase == PH_TIMING);
   assign elapsed = tick - start_eff;

   always_comb begin
      ctl_next = ctl;
      start_next = start;
      fired = 1'b0;
      rsp = '0;
      unique case (item.func)
         FUNC_ARM_CHECK: begin
            // sticky fault lamps
            if (!item.sensor_ok_bits[1]) begin
               ctl_next.baro_led = 1'b1;
            end
            if (!item.sensor_ok_bits[2] && !item.sensor_ok_bits[3]) begin
               ctl_next.inertial_led = 1'b1;
            end
            // gesture phase tracking and arm toggle
            if (gesture_held) begin
               start_next = start_eff;
               if (timing_eff) begin
                  ctl_next.phase = PH_TIMING;
                  if (elapsed > TICK_WIDTH'(cfg.hold_ticks)) begin
                     ctl_next.arm_cmd = !ctl.armed;
                     ctl_next.phase = PH_DONE;
                  end
               end
            end else begin
               ctl_next.phase = PH_IDLE;
            end
            // no arming with an error present
            if (!ctl.armed && ctl_next.arm_cmd && (err != ERR_NONE)) begin
               ctl_next.arm_cmd = 1'b0;
            end
            ctl_next.armed = ctl_next.arm_cmd;
            rsp.arm_error = err;
            rsp.throttle_low = !(thr_x > thr_lim);
         end
         FUNC_STOP_CHECK: begin
            // emergency stop switch with re-arm on low band
            if (aux_x < STOP_LOW_LEVEL) begin
               ctl_next.stop_latched = 1'b0;
            end else if (aux_x > STOP_HIGH_LEVEL) begin
               ctl_next.arm_cmd = 1'b0;
               if (!ctl.stop_latched) begin
                  ctl_next.stop_latched = 1'b1;
                  ctl_next.armed = 1'b0;
                  fired = 1'b1;
               end
            end
            rsp.arm_error = ERR_NONE;
            rsp.throttle_low = 1'b0;
         end
         default: begin
            rsp.arm_error = ERR_NONE;
         end
      endcase
      rsp.armed = ctl_next.armed;
      rsp.arm_request = ctl_next.arm_cmd;
      rsp.baro_fault_seen = ctl_next.baro_led;
      rsp.inertial_fault_seen = ctl_next.inertial_led;
      rsp.stop_fired = fired;
   end

endmodule

// ----- rtl/flight_arming_supervisor_core.sv -----
// ---------------------------------------------------------------------------
// flight_arming_supervisor_core: arming supervisor for a flight controller
// Input register, one evaluation pass, and a response register with stall.
// ---------------------------------------------------------------------------
// A taken request word passes through the input register and then the response register.
// Throughput: one word per cycle; req_stall rises only while the response
// register holds a word that rsp_stall keeps, with the input register full.
// Reset clears control state, disarms, and restores threshold defaults.
// The configuration port never stalls; csr_ready is always high.
module flight_arming_supervisor_core #(
   parameter int unsigned TICK_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   // request channel
   input logic req_valid,
   output logic req_stall,
   input logic req_func,
   input logic [9:0] req_throttle,
   input logic [9:0] req_roll,
   input logic [9:0] req_pitch,
   input logic [9:0] req_yaw,
   input logic [9:0] req_aux_stop,
   input logic [3:0] req_sensor_ok_bits,
   input logic [2:0] req_power_level,
   input logic req_flash_busy,
   input logic [TICK_WIDTH-1:0] req_tick_now,
   // response channel
   output logic rsp_valid,
   input logic rsp_stall,
   output logic rsp_armed,
   output logic rsp_arm_request,
   output logic [2:0] rsp_arm_error,
   output logic rsp_throttle_low,
   output logic rsp_baro_fault_seen,
   output logic rsp_inertial_fault_seen,
   output logic rsp_stop_fired,
   // configuration write channel
   input logic csr_valid,
   output logic csr_ready,
   input logic [fas_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [fas_pkg::CSR_DATA_WIDTH-1:0] csr_data
);
   import fas_pkg::*;

   logic s1_valid_ff, s1_valid_in;
   req_type s1_word_ff;
   logic [TICK_WIDTH-1:0] s1_tick_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   ctl_type ctl_ff, ctl_in;
   logic [TICK_WIDTH-1:0] start_ff, start_in;
   cfg_type cfg_ff, cfg_in;
   logic out_free;
   logic s1_move;
   logic req_take;

   // handshake between the two stages
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_move = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take = req_valid && !req_stall;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   // evaluation pass
   fas_eval #(
      .TICK_WIDTH(TICK_WIDTH)
   ) u_eval (
      .item(s1_word_ff),
      .tick(s1_tick_ff),
      .cfg(cfg_ff),
      .ctl(ctl_ff),
      .start(start_ff),
      .ctl_next(ctl_in),
      .start_next(start_in),
      .rsp(rsp_in)
   );

   // configuration register writes
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THROTTLE_TH: cfg_in.throttle_th = csr_data[8:0];
            CSR_PITCH_TH: cfg_in.pitch_th = csr_data[8:0];
            CSR_ROLL_TH: cfg_in.roll_th = csr_data[8:0];
            CSR_YAW_TH: cfg_in.yaw_th = csr_data[8:0];
            CSR_HOLD_TICKS: cfg_in.hold_ticks = csr_data[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctl_ff <= '{armed: 1'b0, arm_cmd: 1'b0, phase: PH_IDLE,
                     stop_latched: 1'b0, baro_led: 1'b0, inertial_led: 1'b0};
         start_ff <= '0;
         cfg_ff <= '{throttle_th: TH_RESET, pitch_th: TH_RESET, roll_th: TH_RESET,
                     yaw_th: TH_RESET, hold_ticks: HOLD_RESET};
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff <= cfg_in;
         if (s1_move) begin
            ctl_ff <= ctl_in;
            start_ff <= start_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= '{func: req_func, throttle: req_throttle, roll: req_roll,
                         pitch: req_pitch, yaw: req_yaw, aux_stop: req_aux_stop,
                         sensor_ok_bits: req_sensor_ok_bits,
                         power_level: req_power_level, flash_busy: req_flash_busy};
         s1_tick_ff <= req_tick_now;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   // response ports
   assign rsp_valid = rsp_valid_ff;
   assign rsp_armed = rsp_ff.armed;
   assign rsp_arm_request = rsp_ff.arm_request;
   assign rsp_arm_error = rsp_ff.arm_error;
   assign rsp_throttle_low = rsp_ff.throttle_low;
   assign rsp_baro_fault_seen = rsp_ff.baro_fault_seen;
   assign rsp_inertial_fault_seen = rsp_ff.inertial_fault_seen;
   assign rsp_stop_fired = rsp_ff.stop_fired;

   // a fired stop leaves the craft disarmed with no arm command
   a_stop_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.stop_fired |-> !rsp_ff.armed && !rsp_ff.arm_request)
      else $error("stop fired but craft still armed");

   // a stop response carries no error and no throttle flag
   a_stop_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.stop_fired |->
         rsp_ff.arm_error == ERR_NONE && !rsp_ff.throttle_low)
      else $error("stop response with arm-check fields set");

   // input stalls only when a word waits in the input register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked word");

   // gesture phase stays one-hot
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(ctl_ff.phase))
      else $error("gesture phase not one-hot");

   // fault lamps are sticky
   a_leds_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(ctl_ff.baro_led) && !$fell(ctl_ff.inertial_led))
      else $error("sticky fault lamp cleared");

endmodule
